// ----- design/hmix_pkg.sv -----
// shared types, constants and the mixer microprogram
package hmix_pkg;

  localparam int MOTOR_COUNT = 6;
  localparam int CTRL_COUNT  = 4;
  localparam int MIDX_W      = 3;
  localparam int CIDX_W      = 2;
  localparam int PC_W        = 4;
  localparam int FRAC_BITS   = 27;
  localparam int VAL_W       = 16;
  localparam int PROD_W      = 32;
  localparam int ACC_W       = 34;
  localparam int SPAN_W      = 17;
  localparam int P_W         = ACC_W + SPAN_W;
  localparam int PB_W        = P_W + 1;
  localparam int CFG_AW      = 6;

  // function codes of the input stream
  localparam logic [2:0] FN_ROLL   = 3'd0;
  localparam logic [2:0] FN_PITCH  = 3'd1;
  localparam logic [2:0] FN_YAW    = 3'd2;
  localparam logic [2:0] FN_THRUST = 3'd3;
  localparam logic [2:0] FN_ARM    = 3'd4;

  // configuration register indexes
  localparam logic [2:0] REG_GEOM0   = 3'd0;
  localparam logic [2:0] REG_GEOM1   = 3'd1;
  localparam logic [2:0] REG_GEOM2   = 3'd2;
  localparam logic [2:0] REG_GEOM3   = 3'd3;
  localparam logic [2:0] REG_GEOM4   = 3'd4;
  localparam logic [2:0] REG_GEOM5   = 3'd5;
  localparam logic [2:0] REG_ESC_MIN = 3'd6;
  localparam logic [2:0] REG_ESC_MAX = 3'd7;

  // program labels
  localparam logic [PC_W-1:0] PC_MAC_LOOP = 4'd0;
  localparam logic [PC_W-1:0] PC_FIN_LOOP = 4'd7;

  typedef struct packed {
    logic              mul;
    logic [CIDX_W-1:0] sel;
    logic              acc_ld;
    logic              acc_add;
    logic              scale;
    logic              find_min;
    logic              fin;
    logic              m_inc;
    logic              jmp;
    logic [PC_W-1:0]   target;
    logic              done;
  } hmix_cw_t;

  typedef struct packed {
    hmix_cw_t          cw;
    logic [MIDX_W-1:0] m;
    logic              commit;
    logic              busy;
  } hmix_seq_t;

  function automatic hmix_cw_t prog_rom(input logic [PC_W-1:0] pc);
    hmix_cw_t w;
    w = '0;
    case (pc)
      4'd0: begin
        w.mul = 1'b1; w.sel = 2'd0;
      end
      4'd1: begin
        w.mul = 1'b1; w.sel = 2'd1; w.acc_ld = 1'b1;
      end
      4'd2: begin
        w.mul = 1'b1; w.sel = 2'd2; w.acc_add = 1'b1;
      end
      4'd3: begin
        w.mul = 1'b1; w.sel = 2'd3; w.acc_add = 1'b1;
      end
      4'd4: begin
        w.acc_add = 1'b1;
      end
      4'd5: begin
        w.scale = 1'b1;
      end
      4'd6: begin
        w.find_min = 1'b1; w.m_inc = 1'b1; w.jmp = 1'b1; w.target = PC_MAC_LOOP;
      end
      4'd7: begin
        w.fin = 1'b1; w.m_inc = 1'b1; w.jmp = 1'b1; w.target = PC_FIN_LOOP;
      end
      4'd8: begin
        w.done = 1'b1;
      end
      default: begin
        w.done = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- design/hmix_seq.sv -----
// microprogram sequencer: step counter, motor counter and conditional jumps
module hmix_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              out_free_i,
  output hmix_pkg::hmix_seq_t seq_o
);
  import hmix_pkg::*;

  logic [PC_W-1:0]   pc_q, pc_d;
  logic [MIDX_W-1:0] m_q, m_d;
  logic              run_q, run_d;
  hmix_cw_t          cw;
  logic              more;

  assign cw   = prog_rom(pc_q);
  assign more = (m_q != MIDX_W'(MOTOR_COUNT - 1));

  always_comb begin
    pc_d  = pc_q;
    m_d   = m_q;
    run_d = run_q;
    if (start_i) begin
      run_d = 1'b1;
      pc_d  = '0;
      m_d   = '0;
    end else if (run_q) begin
      if (cw.done) begin
        // hold on the last step until the output register is free
        if (out_free_i) begin
          run_d = 1'b0;
          pc_d  = '0;
        end
      end else begin
        if (cw.m_inc) begin
          m_d = more ? m_q + 1'b1 : '0;
        end
        pc_d = (cw.jmp && more) ? cw.target : pc_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q  <= '0;
      m_q   <= '0;
      run_q <= 1'b0;
    end else begin
      pc_q  <= pc_d;
      m_q   <= m_d;
      run_q <= run_d;
    end
  end

  assign seq_o.cw     = run_q ? cw : '0;
  assign seq_o.m      = m_q;
  assign seq_o.commit = run_q & cw.done & out_free_i;
  assign seq_o.busy   = run_q;

endmodule

// ----- design/hmix_dp.sv -----
// mixer datapath: multipliers, accumulator, scaling, minimum and clamp
module hmix_dp (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  hmix_pkg::hmix_seq_t                          seq_i,
  input  logic [hmix_pkg::MOTOR_COUNT-1:0][63:0]       geom_i,
  input  logic [hmix_pkg::CTRL_COUNT-1:0][15:0]        ctrl_i,
  input  logic [15:0]                                  esc_min_i,
  input  logic [15:0]                                  esc_max_i,
  output logic [hmix_pkg::MOTOR_COUNT-1:0][15:0]       res_o
);
  import hmix_pkg::*;

  logic signed [VAL_W-1:0]  coef, cval;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [SPAN_W-1:0] span;
  logic signed [P_W-1:0]    p_q [MOTOR_COUNT];
  logic signed [P_W-1:0]    min_q;
  logic signed [P_W-1:0]    p_sel;
  logic signed [PB_W-1:0]   bias, pb, lim;
  logic [15:0]              fin_val;
  logic [MOTOR_COUNT-1:0][15:0] res_q;

  assign coef  = geom_i[seq_i.m][{seq_i.cw.sel, 4'b0000} +: VAL_W];
  assign cval  = ctrl_i[seq_i.cw.sel];
  assign span  = $signed({1'b0, esc_max_i}) - $signed({1'b0, esc_min_i});
  assign p_sel = p_q[seq_i.m];

  // shift everything up by the shortfall of the smallest motor
  assign bias  = min_q[P_W-1] ? PB_W'(min_q) : '0;
  assign pb    = PB_W'(p_sel) - bias;
  assign lim   = PB_W'(span) <<< FRAC_BITS;
  assign fin_val = (pb > lim) ? esc_max_i
                              : pb[FRAC_BITS +: 16] + esc_min_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      min_q  <= '0;
    end else begin
      if (seq_i.cw.acc_ld) begin
        acc_q <= ACC_W'(prod_q);
      end else if (seq_i.cw.acc_add) begin
        acc_q <= acc_q + ACC_W'(prod_q);
      end
      if (seq_i.cw.find_min) begin
        if (seq_i.m == '0 || p_sel < min_q) begin
          min_q <= p_sel;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_i.cw.mul) begin
      prod_q <= coef * cval;
    end
    if (seq_i.cw.scale) begin
      p_q[seq_i.m] <= acc_q * span;
    end
    if (seq_i.cw.fin) begin
      res_q[seq_i.m] <= fin_val;
    end
  end

  assign res_o = res_q;

endmodule

// ----- design/hexa_motor_mixer.sv -----
// hexacopter motor mixer top level: stream ports, register file, output register
//
// input stream: one transaction per control update; s_axis_tuser carries the
// function code (roll, pitch, yaw, thrust, arm) and s_axis_tdata the signed
// q1.14 value. only a pitch update produces a result; the others just update
// the stored control values or the arm flag and do not start the sequencer
// output stream: one transaction per pitch update with six 16-bit motor
// commands in m_axis_tdata and the arm flag in m_axis_tuser
// a pitch transaction starts the microprogram, which walks each motor through four
// multiply-accumulates, one scaling multiply and a minimum update on the one
// shared datapath (seven steps a motor), then one bias-and-clamp step a motor,
// then a commit step that loads the output register behind m_axis_tvalid
// s_axis_tready is low while the sequencer runs, so a new pitch update is taken
// only once the last one is through; other updates are taken back to back when
// the sequencer is idle
// stall: the result sits in an output register; a new item is taken while it
// waits, and a following result holds on the commit step until it is free
// reset: control values zero, disarmed, geometry zero, esc_min 1100,
// esc_max 2000; no result pending
// configuration: apb, 64-bit data, register i at byte address 8*i, write only
// while the block is idle
module hexa_motor_mixer #(
  parameter logic [15:0] DISARMED_LEVEL = 16'd1000
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [15:0]                 s_axis_tdata,   // value
  input  logic [2:0]                  s_axis_tuser,   // func
  // output stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [95:0]                 m_axis_tdata,   // motor_0 .. motor_5
  output logic [0:0]                  m_axis_tuser,   // armed_out
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hmix_pkg::CFG_AW-1:0] paddr,
  input  logic [63:0]                 pwdata,
  output logic [63:0]                 prdata,
  output logic                        pready
);
  import hmix_pkg::*;

  logic [MOTOR_COUNT-1:0][63:0]  geom_q;
  logic [15:0]                   esc_min_q, esc_max_q;
  logic [CTRL_COUNT-1:0][15:0]   ctrl_q;
  logic                          armed_q;
  logic                          out_valid_q;
  logic [MOTOR_COUNT-1:0][15:0]  motor_q;
  logic                          armed_out_q;

  logic                          in_hs, cfg_wr, start, out_free;
  logic [2:0]                    reg_idx;
  hmix_seq_t                     seq;
  logic [MOTOR_COUNT-1:0][15:0]  res;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_AW-1:3];
  assign cfg_wr  = psel & penable & pwrite & pready;

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      geom_q    <= '0;
      esc_min_q <= 16'd1100;
      esc_max_q <= 16'd2000;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_ESC_MIN: esc_min_q <= pwdata[15:0];
        REG_ESC_MAX: esc_max_q <= pwdata[15:0];
        default:     geom_q[reg_idx] <= pwdata;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ESC_MIN: prdata = {48'd0, esc_min_q};
      REG_ESC_MAX: prdata = {48'd0, esc_max_q};
      default:     prdata = geom_q[reg_idx];
    endcase
  end

  // control value and arm flag updates
  assign s_axis_tready = ~seq.busy;
  assign in_hs         = s_axis_tvalid & s_axis_tready;
  assign start         = in_hs & (s_axis_tuser == FN_PITCH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q  <= '0;
      armed_q <= 1'b0;
    end else if (in_hs) begin
      case (s_axis_tuser)
        FN_ROLL, FN_PITCH, FN_YAW, FN_THRUST: ctrl_q[s_axis_tuser[1:0]] <= s_axis_tdata;
        FN_ARM:  armed_q <= (s_axis_tdata != 16'd0);
        default: ;
      endcase
    end
  end

  hmix_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .out_free_i (out_free),
    .seq_o      (seq)
  );

  hmix_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .seq_i     (seq),
    .geom_i    (geom_q),
    .ctrl_i    (ctrl_q),
    .esc_min_i (esc_min_q),
    .esc_max_i (esc_max_q),
    .res_o     (res)
  );

  // output register, freed in the same cycle the receiver takes it
  assign out_free = ~out_valid_q | m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (seq.commit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq.commit) begin
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        motor_q[i] <= armed_q ? res[i] : DISARMED_LEVEL;
      end
      armed_out_q <= armed_q;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = motor_q;
  assign m_axis_tuser[0] = armed_out_q;

endmodule
